>>> design/prq_pkg.sv
// Package for the priority ready queue: default sizes, command and status codes.
// No dependencies; imported by priority_ready_queue_top.
package prq_pkg;

    // Default sizes
    localparam int PRQ_DEPTH     = 16;
    localparam int PRQ_PRIO_BITS = 8;
    localparam int PRQ_TIME_BITS = 16;

    // Fixed field widths
    localparam int TASK_W   = 4;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

>>> design/prq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used by priority_ready_queue_top for the sorted entries.
module prq_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/priority_ready_queue_top.sv
// Priority ready queue: sorted task list in RAM with a scan-and-shift sequencer.
// Depends on prq_pkg and prq_ram.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. i_cmd selects insert (task placed by clamped priority, then
//   arrival time, then insertion order) or remove (front-most entry with the
//   matching task id is taken out).
//   Result channel: o_valid is high for exactly one cycle with o_status,
//   o_head_valid, o_head_task and o_queued. The receiver cannot stall; the
//   result is simply presented for that one cycle.
//   Configuration: i_max_priority is written at an edge with i_max_priority_we
//   high; the user must do so only while the block is idle (not enforced).
//   Sequence: an insert on a full queue goes straight to the result. Otherwise
//   the scan examines entries one by one, then the entries behind the slot are
//   moved one place, then the head is read back. The scan and the shift share
//   the single RAM read port.
//   busy is high from acceptance until the result is shown; a new command may
//   be accepted in the cycle the result is shown.
//   Reset: synchronous, active low. The queue empties and max_priority returns
//   to all ones; entry RAM contents are not cleared; unwritten entries are never used.
module priority_ready_queue_top
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = PRQ_DEPTH,
    parameter int PRIO_BITS   = PRQ_PRIO_BITS,
    parameter int TIME_BITS   = PRQ_TIME_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cmd,
    input  logic [TASK_W-1:0]                i_task_id,
    input  logic [PRIO_BITS-1:0]             i_priority_req,
    input  logic [TIME_BITS-1:0]             i_arrive_time,
    input  logic                             i_max_priority_we,
    input  logic [PRIO_BITS-1:0]             i_max_priority,
    output logic                             o_valid,
    output logic [STATUS_W-1:0]              o_status,
    output logic                             o_head_valid,
    output logic [TASK_W-1:0]                o_head_task,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_queued
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W  = TASK_W + PRIO_BITS + TIME_BITS;
    localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PREP_DN,
        S_SHIFT_DN,
        S_PLACE,
        S_PREP_UP,
        S_SHIFT_UP,
        S_HEAD,
        S_OUT
    } t_state;

    t_state r_state;

    // Command holding registers
    logic                 r_cmd;
    logic [TASK_W-1:0]    r_id;
    logic [PRIO_BITS-1:0] r_prio;
    logic [TIME_BITS-1:0] r_time;
    logic [PRIO_BITS-1:0] r_max_prio;

    // Queue control
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_src;

    // Result registers
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic                r_head_valid;
    logic [TASK_W-1:0]   r_head_task;
    logic [CNT_W-1:0]    r_queued;

    // RAM ports
    logic              w_we;
    logic [CNT_W-1:0]  w_widx;
    logic [CNT_W-1:0]  w_ridx;
    logic [ENT_W-1:0]  w_wdata;
    logic [ENT_W-1:0]  w_rdata;

    logic                 w_accept;
    logic [PRIO_BITS-1:0] w_clamped;
    logic [TASK_W-1:0]    w_ent_task;
    logic [PRIO_BITS-1:0] w_ent_prio;
    logic [TIME_BITS-1:0] w_ent_time;
    logic                 w_go_on;

    assign w_accept  = start && !busy;
    assign w_clamped = (i_priority_req > r_max_prio) ? r_max_prio : i_priority_req;

    assign w_ent_task = w_rdata[ENT_W-1 -: TASK_W];
    assign w_ent_prio = w_rdata[TIME_BITS +: PRIO_BITS];
    assign w_ent_time = w_rdata[TIME_BITS-1:0];

    // Scan keeps going past an entry that stays ahead (insert) or does not match (remove)
    always_comb begin
        if (r_cmd == CMD_INSERT) begin
            w_go_on = (w_ent_prio != r_prio) ? (w_ent_prio < r_prio) : (w_ent_time <= r_time);
        end else begin
            w_go_on = (w_ent_task != r_id);
        end
    end

    // RAM addressing per state
    always_comb begin
        w_we    = 1'b0;
        w_widx  = '0;
        w_ridx  = '0;
        w_wdata = w_rdata;
        case (r_state)
            S_SCAN: begin
                w_ridx = r_pos + ONE;
            end
            S_PREP_DN: begin
                w_ridx = r_cnt - ONE;
            end
            S_SHIFT_DN: begin
                w_we   = 1'b1;
                w_widx = r_src + ONE;
                w_ridx = r_src - ONE;
            end
            S_PLACE: begin
                w_we    = 1'b1;
                w_widx  = r_pos;
                w_wdata = {r_id, r_prio, r_time};
            end
            S_PREP_UP: begin
                w_ridx = r_pos + ONE;
            end
            S_SHIFT_UP: begin
                w_we   = 1'b1;
                w_widx = r_src - ONE;
                w_ridx = r_src + ONE;
            end
            default: begin
                w_ridx = '0;
            end
        endcase
    end

    prq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_widx[ADDR_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_ridx[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_prio <= '1;
        end else if (i_max_priority_we) begin
            r_max_prio <= i_max_priority;
        end
    end

    // Sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= i_cmd;
                        r_id     <= i_task_id;
                        r_prio   <= w_clamped;
                        r_time   <= i_arrive_time;
                        r_pos    <= '0;
                        r_status <= ST_OK;
                        if (i_cmd == CMD_INSERT && r_cnt >= DEPTH) begin
                            r_status <= ST_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_pos >= r_cnt || !w_go_on) begin
                        if (r_cmd == CMD_INSERT) begin
                            r_state <= S_PREP_DN;
                        end else if (r_pos >= r_cnt) begin
                            r_status <= ST_NOT_FOUND;
                            r_state  <= S_HEAD;
                        end else begin
                            r_state <= S_PREP_UP;
                        end
                    end else begin
                        r_pos <= r_pos + ONE;
                    end
                end
                S_PREP_DN: begin
                    if (r_cnt == r_pos) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_src   <= r_cnt - ONE;
                        r_state <= S_SHIFT_DN;
                    end
                end
                S_SHIFT_DN: begin
                    if (r_src == r_pos) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_src <= r_src - ONE;
                    end
                end
                S_PLACE: begin
                    r_cnt   <= r_cnt + ONE;
                    r_state <= S_HEAD;
                end
                S_PREP_UP: begin
                    if (r_pos + ONE >= r_cnt) begin
                        r_cnt   <= r_cnt - ONE;
                        r_state <= S_HEAD;
                    end else begin
                        r_src   <= r_pos + ONE;
                        r_state <= S_SHIFT_UP;
                    end
                end
                S_SHIFT_UP: begin
                    if (r_src + ONE >= r_cnt) begin
                        r_cnt   <= r_cnt - ONE;
                        r_state <= S_HEAD;
                    end else begin
                        r_src <= r_src + ONE;
                    end
                end
                S_HEAD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out_valid  <= 1'b1;
                    r_head_valid <= (r_cnt != '0);
                    r_head_task  <= (r_cnt != '0) ? w_ent_task : '0;
                    r_queued     <= r_cnt;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_head_valid = r_head_valid;
    assign o_head_task  = r_head_task;
    assign o_queued     = r_queued;

    // Occupancy never exceeds the RAM depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH)
        else $error("queue count beyond depth");

    // An accepted command makes the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("command accepted but block not busy");

    // Result count matches the occupancy and head flag follows it
    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_queued == r_cnt) && (o_head_valid == (o_queued != '0)))
        else $error("result count or head flag inconsistent");

    // Shift source always points inside the occupied part
    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_DN || r_state == S_SHIFT_UP) |-> (r_src < r_cnt))
        else $error("shift source outside queue");

    // A full-queue insert changes nothing and reports full
    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_queued == DEPTH))
        else $error("full status with queue not full");

endmodule
